### hdl/lkvc_pkg.sv
// ---------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, codes and payload types for the cache cell chain.
// ---------------------------------------------------------------------------
package lkvc_pkg;

   // number of entries held by the cell chain
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int KEY_W    = 32;
   localparam int DATA_W   = 32;

   // access codes
   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   // request transfer payload
   typedef struct packed {
      logic              mode;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] value_in;
   } req_type;

   // response transfer payload
   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] value_out;
   } rsp_type;

   // contents of one cell, handed from a cell to its neighbor
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
   } slot_type;

endpackage

### hdl/lkvc_cell.sv
// ---------------------------------------------------------------------------
// LRU cache cell
// One entry of the recency chain: compares its key against the lookup key
// and, when told to shift, takes over the entry of its upstream neighbor.
// ---------------------------------------------------------------------------
module lkvc_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift_en,
   input  lkvc_pkg::slot_type         prev_slot,
   input  logic [lkvc_pkg::KEY_W-1:0] lookup_key,
   output lkvc_pkg::slot_type         slot_out,
   output logic                       match
);
   import lkvc_pkg::*;

   logic              valid_ff, valid_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [DATA_W-1:0] data_ff, data_in;

   // take the neighbor's entry on a shift, otherwise hold
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      if (shift_en) begin
         valid_in = prev_slot.valid;
         key_in   = prev_slot.key;
         data_in  = prev_slot.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // key and data need no reset: they are only seen behind valid
   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
   end

   assign match    = valid_ff && (key_ff == lookup_key);
   assign slot_out = '{valid: valid_ff, key: key_ff, data: data_ff};

endmodule

### hdl/lru_key_value_cache_unit.sv
// ---------------------------------------------------------------------------
// LRU key-value cache
// Fully associative get/put store kept as a chain of cells ordered by
// recency: cell 0 holds the most recent entry, the last cell the least.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   req     | in        | req_valid / req_stall | req_payload (mode,key,value)
//   rsp     | out       | rsp_valid / rsp_stall | rsp_payload (hit, value_out)
//
// An access matches its key over all cells in the transfer cycle and is
// held in the lookup register; the chain shift and the response write
// follow on commit, and no new access is taken while that register is full.
// The next match needs the chain as the previous access leaves it.
// Reset clears every cell's valid bit at once; the store starts empty.
// A stalled response holds the pending access in the lookup register and
// the request side stalls until the response register frees up.
// ---------------------------------------------------------------------------
module lru_key_value_cache_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lkvc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lkvc_pkg::rsp_type rsp_payload
);
   import lkvc_pkg::*;

   slot_type            chain [CAPACITY+1];
   logic [CAPACITY-1:0] match;
   logic [CAPACITY-1:0] shift_en;

   logic                req_xfer;
   logic                commit;
   logic                look_hit;
   logic [IDX_W-1:0]    look_pos;
   logic [DATA_W-1:0]   look_data;

   // lookup register, holds the access between match and commit
   logic                b_valid_ff, b_valid_in;
   logic                b_mode_ff;
   logic [KEY_W-1:0]    b_key_ff;
   logic [DATA_W-1:0]   b_value_ff;
   logic                b_hit_ff;
   logic [IDX_W-1:0]    b_pos_ff;
   logic [DATA_W-1:0]   b_data_ff;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_payload_ff, rsp_payload_in;

   assign req_stall = b_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign commit    = b_valid_ff && (!rsp_valid_ff || !rsp_stall);

   // new most-recent entry enters at the head of the chain
   assign chain[0] = '{valid: 1'b1,
                       key:   b_key_ff,
                       data:  (b_mode_ff == MODE_PUT) ? b_value_ff : b_data_ff};

   // cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      // a hit at position p rotates cells 0..p; a put miss shifts them all
      assign shift_en[i] = commit && (b_hit_ff || (b_mode_ff == MODE_PUT))
                           && (!b_hit_ff || (IDX_W'(i) <= b_pos_ff));

      lkvc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en[i]),
         .prev_slot  (chain[i]),
         .lookup_key (req_payload.key),
         .slot_out   (chain[i+1]),
         .match      (match[i])
      );
   end

   // hit position and data: at most one cell matches
   always_comb begin
      look_hit  = |match;
      look_pos  = '0;
      look_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match[i]) begin
            look_pos  = look_pos | IDX_W'(i);
            look_data = look_data | chain[i+1].data;
         end
      end
   end

   // lookup register control
   always_comb begin
      b_valid_in = b_valid_ff;
      if (req_xfer) begin
         b_valid_in = 1'b1;
      end else if (commit) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         b_mode_ff  <= req_payload.mode;
         b_key_ff   <= req_payload.key;
         b_value_ff <= req_payload.value_in;
         b_hit_ff   <= look_hit;
         b_pos_ff   <= look_pos;
         b_data_ff  <= look_data;
      end
   end

   // response register: loads on commit, clears when taken
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (commit) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.hit       = b_hit_ff;
         rsp_payload_in.value_out = (b_hit_ff && (b_mode_ff == MODE_GET)) ? b_data_ff : '0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### hdl/lkvc_checker.sv
// ---------------------------------------------------------------------------
// LRU cache port checker
// Port-level properties of the cache, attached to the top level by bind.
// ---------------------------------------------------------------------------
module lkvc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input lkvc_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lkvc_pkg::rsp_type rsp_payload
);
   import lkvc_pkg::*;

   // one access in flight: a request transfer blocks the next cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted on back-to-back cycles");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

   // a put whose response side is free at commit answers with zero data
   a_put_zero: assert property (@(posedge clock) disable iff (reset)
      ((req_valid && !req_stall && (req_payload.mode == MODE_PUT))
       ##1 (!rsp_valid || !rsp_stall))
      |=> (rsp_valid && (rsp_payload.value_out == '0)))
      else $error("put response missing or carries data");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);
